// ===== rtl/idfs_pkg.sv =====
// Shared constants, types and codes of the isochronous descriptor frame scheduler.
`timescale 1ns / 1ps

package idfs_pkg;

    // Sizes of the slot ring and the frame list.
    localparam int SLOT_COUNT      = 8;
    localparam int FRAME_LIST_SIZE = 1024;
    localparam int MAX_PACKET      = 1023;
    localparam int RESULT_CAP      = 8;

    // Derived widths.
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NCNT_W = $clog2(RESULT_CAP + 1);

    // Token constants.
    localparam logic [7:0]  PID_IN   = 8'h69;
    localparam logic [7:0]  PID_OUT  = 8'he1;
    localparam logic [10:0] LEN_NONE = 11'h7ff;

    // Command codes of an input word.
    typedef enum logic [1:0] {
        OP_QUEUE    = 2'd0,
        OP_START    = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_NONE     = 2'd3
    } idfs_op_t;

    // Outcome codes of a result word.
    typedef enum logic [3:0] {
        OC_QUEUED    = 4'd0,
        OC_NO_FREE   = 4'd1,
        OC_STARTED   = 4'd2,
        OC_DROPPED   = 4'd3,
        OC_NONE      = 4'd4,
        OC_DONE_OK   = 4'd5,
        OC_DONE_ERR  = 4'd6,
        OC_TIMEOUT   = 4'd7,
        OC_PENDING   = 4'd8,
        OC_SLOT_IDLE = 4'd9
    } idfs_outcome_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_INTERVAL  = 2'd0,
        REG_DEV_ADDR  = 2'd1,
        REG_ENDPOINT  = 2'd2,
        REG_DIR_IN    = 2'd3
    } idfs_reg_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QSCAN,
        ST_QFRAME,
        ST_QWRITE,
        ST_QFULL,
        ST_START,
        ST_COMP
    } idfs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic frame_calc;
        logic q_commit;
        logic q_full;
        logic s_emit;
        logic s_none;
        logic c_emit;
    } idfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic free_here;
        logic elig_here;
        logic none_to_start;
        logic scan_end;
        logic start_last;
        logic out_free;
    } idfs_status_t;

endpackage

// ===== rtl/idfs_in_if.sv =====
// Input channel: one command word with its operands.
`timescale 1ns / 1ps

interface idfs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] requested_frame;
    logic [15:0] request_length;
    logic        has_buffer;
    logic [31:0] host_frame;
    logic [2:0]  slot_index;
    logic [31:0] status_word;

    modport source (
        output valid, command, requested_frame, request_length, has_buffer,
               host_frame, slot_index, status_word,
        input  ready
    );

    modport sink (
        input  valid, command, requested_frame, request_length, has_buffer,
               host_frame, slot_index, status_word,
        output ready
    );
endinterface

// ===== rtl/idfs_out_if.sv =====
// Output channel: one result word.
`timescale 1ns / 1ps

interface idfs_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  outcome;
    logic [2:0]  result_slot;
    logic [31:0] scheduled_frame;
    logic [31:0] token_word;
    logic [9:0]  packet_length;
    logic [10:0] actual_length;
    logic        last;

    modport source (
        output valid, outcome, result_slot, scheduled_frame, token_word,
               packet_length, actual_length, last,
        input  ready
    );

    modport sink (
        input  valid, outcome, result_slot, scheduled_frame, token_word,
               packet_length, actual_length, last,
        output ready
    );
endinterface

// ===== rtl/idfs_ctrl.sv =====
// Controller state machine that sequences queue, start and complete commands.
`timescale 1ns / 1ps

module idfs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  idfs_pkg::idfs_op_t    in_op,
    input  idfs_pkg::idfs_status_t status,
    output logic                  in_ready,
    output idfs_pkg::idfs_cmd_t   cmd
);
    import idfs_pkg::*;

    idfs_state_t state_reg;
    idfs_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_QUEUE:    state_next = ST_QSCAN;
                        OP_START:    state_next = ST_START;
                        OP_COMPLETE: state_next = ST_COMP;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_QSCAN:
            begin
                if (status.free_here)
                begin
                    state_next = ST_QFRAME;
                end
                else if (status.scan_end)
                begin
                    state_next = ST_QFULL;
                end
            end
            ST_QFRAME:
            begin
                state_next = ST_QWRITE;
            end
            ST_QWRITE, ST_QFULL, ST_COMP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                if (status.none_to_start)
                begin
                    if (status.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (status.elig_here && status.out_free && status.start_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_QSCAN:
            begin
                cmd.step = !status.free_here && !status.scan_end;
            end
            ST_QFRAME:
            begin
                cmd.frame_calc = 1'b1;
            end
            ST_QWRITE:
            begin
                cmd.q_commit = status.out_free;
            end
            ST_QFULL:
            begin
                cmd.q_full = status.out_free;
            end
            ST_START:
            begin
                if (status.none_to_start)
                begin
                    cmd.s_none = status.out_free;
                end
                else if (status.elig_here)
                begin
                    cmd.s_emit = status.out_free;
                    cmd.step   = status.out_free;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_COMP:
            begin
                cmd.c_emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/idfs_dp.sv =====
// Datapath: slot store, frame arithmetic, token building and result register.
`timescale 1ns / 1ps

module idfs_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  idfs_pkg::idfs_cmd_t    cmd,
    output idfs_pkg::idfs_status_t status,
    // Configuration writes
    input  logic                   wr_en,
    input  logic [1:0]             wr_index,
    input  logic [15:0]            wr_data,
    // Input word operands
    input  logic [1:0]             in_command,
    input  logic [31:0]            in_requested_frame,
    input  logic [15:0]            in_request_length,
    input  logic                   in_has_buffer,
    input  logic [31:0]            in_host_frame,
    input  logic [2:0]             in_slot_index,
    input  logic [31:0]            in_status_word,
    // Result word
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [3:0]             out_outcome,
    output logic [2:0]             out_result_slot,
    output logic [31:0]            out_scheduled_frame,
    output logic [31:0]            out_token_word,
    output logic [9:0]             out_packet_length,
    output logic [10:0]            out_actual_length,
    output logic                   out_last
);
    import idfs_pkg::*;

    // Configuration registers.
    logic [15:0] ivl_reg, ivl_next;
    logic [6:0]  addr_reg, addr_next;
    logic [3:0]  ep_reg, ep_next;
    logic        dir_reg, dir_next;

    // Latched operands of the current word.
    logic [31:0] req_reg, cur_reg, stat_reg;
    logic [15:0] len_reg;
    logic        buf_reg;
    logic [2:0]  sidx_reg;

    // Sequencing and scheduling state.
    logic [SLOT_W-1:0]     ptr_reg, ptr_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [NCNT_W-1:0]     n_reg, n_next;
    logic [SLOT_W-1:0]     next_slot_reg, next_slot_next;
    logic [31:0]           pending_reg, pending_next;
    logic [31:0]           frame_reg, frame_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;

    // Slot store, written on each queue commit; it has no reset.
    logic [31:0] slot_frame_mem [SLOT_COUNT];
    logic [15:0] slot_len_mem   [SLOT_COUNT];
    logic        slot_buf_mem   [SLOT_COUNT];

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  outcome_reg, outcome_next;
    logic [2:0]  rslot_reg, rslot_next;
    logic [31:0] sframe_reg, sframe_next;
    logic [31:0] token_reg, token_next;
    logic [9:0]  plen_reg, plen_next;
    logic [10:0] alen_reg, alen_next;
    logic        last_reg, last_next;

    // Working values.
    logic [15:0]           ivl_eff;
    logic [31:0]           lead, win, cur_lead, diff, auto_frame, cand, fin;
    logic signed [33:0]    diff_s, lim_s;
    logic                  keep;
    logic [31:0]           rd_frame;
    logic [15:0]           rd_len;
    logic                  rd_buf;
    logic [9:0]            len_sat;
    logic [10:0]           field;
    logic [31:0]           token;
    logic                  drop, timed_out, err, slot_ok;
    logic [10:0]           actual;
    logic [SLOT_COUNT-1:0] elig, rest;
    logic [SLOT_W-1:0]     ptr_inc;
    logic [NCNT_W-1:0]     n_inc;
    logic                  emit;

    // Frame choice for a queued transfer.
    always_comb
    begin
        ivl_eff    = (ivl_reg == 16'd0) ? 16'd1 : ivl_reg;
        lead       = {13'd0, ivl_eff, 3'd0};
        win        = {14'd0, ivl_eff, 2'd0};
        cur_lead   = cur_reg + lead;
        diff       = req_reg - cur_reg;
        diff_s     = signed'({{2{diff[31]}}, diff});
        lim_s      = signed'(34'(FRAME_LIST_SIZE)) - signed'({2'b00, lead});
        keep       = (diff_s > 34'sd0) && (diff_s < lim_s);
        auto_frame = (pending_reg > cur_reg) ? pending_reg : cur_lead;
        cand       = (req_reg == 32'd0) ? auto_frame : (keep ? req_reg : cur_lead);
        fin        = (frame_reg < cur_reg) ? cur_lead : frame_reg;
    end

    // Slot read at the pointer, token and completion decode.
    always_comb
    begin
        rd_frame  = slot_frame_mem[ptr_reg];
        rd_len    = slot_len_mem[ptr_reg];
        rd_buf    = slot_buf_mem[ptr_reg];
        len_sat   = (rd_len > 16'(MAX_PACKET)) ? 10'(MAX_PACKET) : rd_len[9:0];
        drop      = (len_sat != 10'd0) && !rd_buf;
        field     = (len_sat != 10'd0) ? {1'b0, len_sat - 10'd1} : LEN_NONE;
        token     = {field, 2'b00, ep_reg, addr_reg, dir_reg ? PID_IN : PID_OUT};
        timed_out = cur_reg > (rd_frame + win);
        err       = stat_reg[17] || stat_reg[18] || stat_reg[20] || stat_reg[21];
        actual    = (stat_reg[10:0] == LEN_NONE) ? 11'd0 : stat_reg[10:0] + 11'd1;
        slot_ok   = (32'(sidx_reg) < 32'(SLOT_COUNT)) && active_reg[ptr_reg];
        elig      = valid_reg & ~active_reg;
        rest      = (elig >> ptr_reg) >> 1;
        ptr_inc   = (ptr_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : ptr_reg + SLOT_W'(1);
        n_inc     = n_reg + NCNT_W'(1);
    end

    // Status toward the controller.
    always_comb
    begin
        status.free_here     = !valid_reg[ptr_reg] && !active_reg[ptr_reg];
        status.elig_here     = elig[ptr_reg];
        status.none_to_start = (n_reg == '0) && (elig == '0);
        status.scan_end      = (cnt_reg == SLOT_W'(SLOT_COUNT - 1));
        status.start_last    = (n_inc == NCNT_W'(RESULT_CAP)) || (rest == '0);
        status.out_free      = !out_valid_reg || out_ready;
    end

    assign emit = cmd.q_commit || cmd.q_full || cmd.s_emit || cmd.s_none || cmd.c_emit;

    // Next values of the control state and the result register.
    always_comb
    begin
        ivl_next       = ivl_reg;
        addr_next      = addr_reg;
        ep_next        = ep_reg;
        dir_next       = dir_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        next_slot_next = next_slot_reg;
        pending_next   = pending_reg;
        frame_next     = frame_reg;
        valid_next     = valid_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !out_ready;
        outcome_next   = outcome_reg;
        rslot_next     = rslot_reg;
        sframe_next    = sframe_reg;
        token_next     = token_reg;
        plen_next      = plen_reg;
        alen_next      = alen_reg;
        last_next      = last_reg;

        // Configuration writes.
        if (wr_en)
        begin
            case (idfs_reg_t'(wr_index))
                REG_INTERVAL: ivl_next  = wr_data;
                REG_DEV_ADDR: addr_next = wr_data[6:0];
                REG_ENDPOINT: ep_next   = wr_data[3:0];
                REG_DIR_IN:   dir_next  = wr_data[0];
                default:      ivl_next  = ivl_reg;
            endcase
        end

        // Pointer setup when a word is taken.
        if (cmd.load)
        begin
            case (idfs_op_t'(in_command))
                OP_QUEUE:
                begin
                    ptr_next = next_slot_reg;
                    cnt_next = '0;
                end
                OP_START:
                begin
                    ptr_next = '0;
                    n_next   = '0;
                end
                OP_COMPLETE:
                begin
                    ptr_next = SLOT_W'(in_slot_index);
                end
                default:
                begin
                    ptr_next = ptr_reg;
                end
            endcase
        end

        // Scan step.
        if (cmd.step)
        begin
            ptr_next = ptr_inc;
            cnt_next = cnt_reg + SLOT_W'(1);
        end

        if (cmd.frame_calc)
        begin
            frame_next = cand;
        end

        // Default result fields for any emitted word.
        if (emit)
        begin
            out_valid_next = 1'b1;
            rslot_next     = 3'(ptr_reg);
            sframe_next    = rd_frame;
            token_next     = '0;
            plen_next      = '0;
            alen_next      = '0;
            last_next      = 1'b1;
        end

        // Queue commit.
        if (cmd.q_commit)
        begin
            valid_next[ptr_reg] = 1'b1;
            next_slot_next      = ptr_inc;
            pending_next        = fin + {16'd0, ivl_eff};
            outcome_next        = OC_QUEUED;
            sframe_next         = fin;
        end

        if (cmd.q_full)
        begin
            outcome_next = OC_NO_FREE;
            rslot_next   = '0;
            sframe_next  = '0;
        end

        // Start or drop one slot.
        if (cmd.s_emit)
        begin
            n_next    = n_inc;
            plen_next = len_sat;
            last_next = status.start_last;
            if (drop)
            begin
                valid_next[ptr_reg] = 1'b0;
                outcome_next        = OC_DROPPED;
            end
            else
            begin
                active_next[ptr_reg] = 1'b1;
                outcome_next         = OC_STARTED;
                token_next           = token;
            end
        end

        if (cmd.s_none)
        begin
            outcome_next = OC_NONE;
            rslot_next   = '0;
            sframe_next  = '0;
        end

        // Completion check.
        if (cmd.c_emit)
        begin
            if (!slot_ok)
            begin
                outcome_next = OC_SLOT_IDLE;
                rslot_next   = sidx_reg;
                sframe_next  = '0;
            end
            else if (stat_reg[23])
            begin
                if (timed_out)
                begin
                    active_next[ptr_reg] = 1'b0;
                    valid_next[ptr_reg]  = 1'b0;
                    outcome_next         = OC_TIMEOUT;
                end
                else
                begin
                    outcome_next = OC_PENDING;
                end
            end
            else
            begin
                active_next[ptr_reg] = 1'b0;
                valid_next[ptr_reg]  = 1'b0;
                outcome_next         = err ? OC_DONE_ERR : OC_DONE_OK;
                alen_next            = actual;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivl_reg       <= 16'd1;
            addr_reg      <= '0;
            ep_reg        <= '0;
            dir_reg       <= 1'b0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            next_slot_reg <= '0;
            pending_reg   <= '0;
            valid_reg     <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ivl_reg       <= ivl_next;
            addr_reg      <= addr_next;
            ep_reg        <= ep_next;
            dir_reg       <= dir_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            next_slot_reg <= next_slot_next;
            pending_reg   <= pending_next;
            valid_reg     <= valid_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers and operand capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= in_requested_frame;
            len_reg  <= in_request_length;
            buf_reg  <= in_has_buffer;
            cur_reg  <= in_host_frame;
            sidx_reg <= in_slot_index;
            stat_reg <= in_status_word;
        end
        frame_reg   <= frame_next;
        outcome_reg <= outcome_next;
        rslot_reg   <= rslot_next;
        sframe_reg  <= sframe_next;
        token_reg   <= token_next;
        plen_reg    <= plen_next;
        alen_reg    <= alen_next;
        last_reg    <= last_next;
    end

    // Slot store write on queue commit.
    always_ff @(posedge clk)
    begin
        if (cmd.q_commit)
        begin
            slot_frame_mem[ptr_reg] <= fin;
            slot_len_mem[ptr_reg]   <= len_reg;
            slot_buf_mem[ptr_reg]   <= buf_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_outcome         = outcome_reg;
    assign out_result_slot     = rslot_reg;
    assign out_scheduled_frame = sframe_reg;
    assign out_token_word      = token_reg;
    assign out_packet_length   = plen_reg;
    assign out_actual_length   = alen_reg;
    assign out_last            = last_reg;

endmodule

// ===== rtl/iso_descriptor_frame_scheduler.sv =====
// Top level of the isochronous descriptor frame scheduler.
// One command word is taken at a time; the block takes the next word only once the
// previous one has been fully worked off, while its last result may still sit in the
// output register. A queue word runs a round-robin search for a free slot, one slot per
// cycle from the slot after the last one queued, then a registered frame calculation
// and the write of the slot; if no slot is free, the search ends in a no-free result.
// A start word scans the slots from slot 0, starting or dropping each eligible slot,
// and emits up to eight results; a complete word checks one slot. Every cycle that
// emits a result waits while the output register is still full. Configuration writes
// are taken at any time but are meant for an idle block. There is no clearing pass
// after reset.
`timescale 1ns / 1ps

module iso_descriptor_frame_scheduler (
    input  logic            clk,
    input  logic            rst_n,
    idfs_in_if.sink         items,
    idfs_out_if.source      results,
    input  logic            wr_en,
    input  logic [1:0]      wr_index,
    input  logic [15:0]     wr_data
);
    import idfs_pkg::*;

    idfs_cmd_t    cmd;
    idfs_status_t status;
    logic         ready;

    // Sequencer.
    idfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_op    (idfs_op_t'(items.command)),
        .status   (status),
        .in_ready (ready),
        .cmd      (cmd)
    );

    assign items.ready = ready;

    // Slot store and arithmetic.
    idfs_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .wr_en               (wr_en),
        .wr_index            (wr_index),
        .wr_data             (wr_data),
        .in_command          (items.command),
        .in_requested_frame  (items.requested_frame),
        .in_request_length   (items.request_length),
        .in_has_buffer       (items.has_buffer),
        .in_host_frame       (items.host_frame),
        .in_slot_index       (items.slot_index),
        .in_status_word      (items.status_word),
        .out_ready           (results.ready),
        .out_valid           (results.valid),
        .out_outcome         (results.outcome),
        .out_result_slot     (results.result_slot),
        .out_scheduled_frame (results.scheduled_frame),
        .out_token_word      (results.token_word),
        .out_packet_length   (results.packet_length),
        .out_actual_length   (results.actual_length),
        .out_last            (results.last)
    );

endmodule
